// ===== rtl/trmds_pkg.sv =====
// trmds_pkg: shared widths, sequencer codes and the control/status structs
// of the tree rerooting block. No dependencies.
package trmds_pkg;

  localparam int ID_W = 11;
  localparam int ST_W = 5;

  localparam logic [ST_W-1:0] ST_CLR      = 5'd0;
  localparam logic [ST_W-1:0] ST_IDLE     = 5'd1;
  localparam logic [ST_W-1:0] ST_LD_RA    = 5'd2;
  localparam logic [ST_W-1:0] ST_LD_WA    = 5'd3;
  localparam logic [ST_W-1:0] ST_LD_RB    = 5'd4;
  localparam logic [ST_W-1:0] ST_LD_WB    = 5'd5;
  localparam logic [ST_W-1:0] ST_BFS_INIT = 5'd6;
  localparam logic [ST_W-1:0] ST_BFS_POP  = 5'd7;
  localparam logic [ST_W-1:0] ST_BFS_U    = 5'd8;
  localparam logic [ST_W-1:0] ST_BFS_U2   = 5'd9;
  localparam logic [ST_W-1:0] ST_BFS_E    = 5'd10;
  localparam logic [ST_W-1:0] ST_BFS_V    = 5'd11;
  localparam logic [ST_W-1:0] ST_BFS_S    = 5'd12;
  localparam logic [ST_W-1:0] ST_REV_A    = 5'd13;
  localparam logic [ST_W-1:0] ST_REV_B    = 5'd14;
  localparam logic [ST_W-1:0] ST_REV_C    = 5'd15;
  localparam logic [ST_W-1:0] ST_REV_D    = 5'd16;
  localparam logic [ST_W-1:0] ST_FWD_INIT = 5'd17;
  localparam logic [ST_W-1:0] ST_FWD_A    = 5'd18;
  localparam logic [ST_W-1:0] ST_FWD_B    = 5'd19;
  localparam logic [ST_W-1:0] ST_FWD_C    = 5'd20;
  localparam logic [ST_W-1:0] ST_FWD_D    = 5'd21;
  localparam logic [ST_W-1:0] ST_FIN      = 5'd22;

  typedef struct packed {
    logic [ST_W-1:0] op;
    logic            take;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic ld_ok;
    logic last;
    logic q_empty;
    logic e_zero;
    logic v_ok;
    logic rev_done;
    logic fwd_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/trmds_ram.sv =====
// trmds_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module trmds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/trmds_ctrl.sv =====
// trmds_ctrl: sequencer for edge loading, walk, subtree and reroot passes.
// Depends on trmds_pkg.
module trmds_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  trmds_pkg::sts_t   sts,
  output trmds_pkg::cmd_t   cmd
);
  import trmds_pkg::*;

  logic [ST_W-1:0] state_r;
  logic [ST_W-1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:      if (sts.clr_done) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_valid) state_nxt = ST_LD_RA;
      ST_LD_RA: begin
        if (sts.ld_ok) state_nxt = ST_LD_WA;
        else if (sts.last) state_nxt = ST_BFS_INIT;
        else state_nxt = ST_IDLE;
      end
      ST_LD_WA:    state_nxt = ST_LD_RB;
      ST_LD_RB:    state_nxt = ST_LD_WB;
      ST_LD_WB:    state_nxt = sts.last ? ST_BFS_INIT : ST_IDLE;
      ST_BFS_INIT: state_nxt = ST_BFS_POP;
      ST_BFS_POP:  state_nxt = sts.q_empty ? ST_REV_A : ST_BFS_U;
      ST_BFS_U:    state_nxt = ST_BFS_U2;
      ST_BFS_U2:   state_nxt = ST_BFS_E;
      ST_BFS_E:    state_nxt = sts.e_zero ? ST_BFS_POP : ST_BFS_V;
      ST_BFS_V:    state_nxt = sts.v_ok ? ST_BFS_S : ST_BFS_E;
      ST_BFS_S:    state_nxt = ST_BFS_E;
      ST_REV_A:    state_nxt = sts.rev_done ? ST_FWD_INIT : ST_REV_B;
      ST_REV_B:    state_nxt = ST_REV_C;
      ST_REV_C:    state_nxt = ST_REV_D;
      ST_REV_D:    state_nxt = ST_REV_A;
      ST_FWD_INIT: state_nxt = ST_FWD_A;
      ST_FWD_A:    state_nxt = sts.fwd_done ? ST_FIN : ST_FWD_B;
      ST_FWD_B:    state_nxt = ST_FWD_C;
      ST_FWD_C:    state_nxt = ST_FWD_D;
      ST_FWD_D:    state_nxt = ST_FWD_A;
      ST_FIN:      if (sts.out_free) state_nxt = ST_CLR;
      default:     state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign cmd.op   = state_r;
  assign cmd.take = (state_r == ST_IDLE) && in_valid;

endmodule

// ===== rtl/trmds_dpath.sv =====
// trmds_dpath: adjacency, walk and per-node memories, counters and result
// register. Depends on trmds_pkg and trmds_ram.
module trmds_dpath #(
  parameter int MAX_NODES = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  trmds_pkg::cmd_t             cmd,
  output trmds_pkg::sts_t             sts,
  input  logic [trmds_pkg::ID_W-1:0]  in_edge_from,
  input  logic [trmds_pkg::ID_W-1:0]  in_edge_to,
  input  logic                        in_last_edge,
  input  logic                        cfg_we,
  input  logic [trmds_pkg::ID_W-1:0]  cfg_node_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [trmds_pkg::ID_W-1:0]  out_best_root
);
  import trmds_pkg::*;

  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int SLOT_AW = $clog2(2 * MAX_NODES);
  localparam int CNT_W   = NODE_AW + 1;
  localparam int DEP_W   = NODE_AW;
  localparam int SIZE_W  = NODE_AW + 1;
  localparam int TOT_W   = 2 * NODE_AW + 2;
  localparam int ID_MAXV = (1 << ID_W) - 1;
  localparam int N_CAP   = (MAX_NODES > ID_MAXV) ? ID_MAXV : MAX_NODES;

  function automatic logic [NODE_AW-1:0] nidx(input logic [ID_W-1:0] x);
    nidx = NODE_AW'(x - ID_W'(1));
  endfunction

  logic [ID_W-1:0]    n_r;
  logic [ID_W-1:0]    n_eff;
  logic [SLOT_AW-1:0] s_r;
  logic [NODE_AW-1:0] clr_r;
  logic               out_valid_r;
  logic [ID_W-1:0]    out_best_r;
  logic [ID_W-1:0]    a_r, b_r;
  logic               last_r;
  logic [CNT_W-1:0]   qh_r, qt_r, i_r;
  logic [ID_W-1:0]    u_r, v_r, p_r, best_r;
  logic [SLOT_AW-1:0] e_r;
  logic [DEP_W-1:0]   du_r;
  logic [SIZE_W-1:0]  su_r;
  logic [TOT_W-1:0]   tot1_r, bestval_r;
  logic [TOT_W:0]     tsum;
  logic [TOT_W-1:0]   tnew;
  logic               out_free;

  logic               hd_we, sn_we, tg_we, lk_we, pa_we, dp_we, sz_we, tt_we, od_we;
  logic [NODE_AW-1:0] hd_wa, hd_ra, sn_wa, sn_ra, pa_wa, pa_ra, dp_wa, dp_ra;
  logic [NODE_AW-1:0] sz_wa, sz_ra, tt_wa, tt_ra, od_wa, od_ra;
  logic [SLOT_AW-1:0] tg_wa, tg_ra, lk_wa, lk_ra;
  logic [SLOT_AW-1:0] hd_wd, hd_rd, lk_wd, lk_rd;
  logic               sn_wd, sn_rd;
  logic [ID_W-1:0]    tg_wd, tg_rd, pa_wd, pa_rd, od_wd, od_rd;
  logic [DEP_W-1:0]   dp_wd, dp_rd;
  logic [SIZE_W-1:0]  sz_wd, sz_rd;
  logic [TOT_W-1:0]   tt_wd, tt_rd;

  assign n_eff = (n_r == '0) ? ID_W'(1) :
                 (n_r > ID_W'(N_CAP)) ? ID_W'(N_CAP) : n_r;

  assign tsum = {1'b0, tt_rd} + (TOT_W + 1)'(n_eff) - ((TOT_W + 1)'(su_r) << 1);
  assign tnew = tsum[TOT_W-1:0];
  assign out_free = !out_valid_r || !out_stall;

  assign sts.clr_done = (clr_r == NODE_AW'(MAX_NODES - 1));
  assign sts.ld_ok    = (a_r != '0) && (a_r <= n_eff) && (b_r != '0) && (b_r <= n_eff) &&
                        ((32'(s_r) + 32'd2) <= 32'(2 * MAX_NODES - 2));
  assign sts.last     = last_r;
  assign sts.q_empty  = (qh_r == qt_r);
  assign sts.e_zero   = (e_r == '0);
  assign sts.v_ok     = (tg_rd != '0) && (tg_rd <= n_eff);
  assign sts.rev_done = (i_r == '0);
  assign sts.fwd_done = (i_r == qt_r);
  assign sts.out_free = out_free;

  always_comb begin
    hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_ra = '0;
    sn_we = 1'b0; sn_wa = '0; sn_wd = 1'b0; sn_ra = '0;
    tg_we = 1'b0; tg_wa = '0; tg_wd = '0; tg_ra = '0;
    lk_we = 1'b0; lk_wa = '0; lk_wd = '0; lk_ra = '0;
    pa_we = 1'b0; pa_wa = '0; pa_wd = '0; pa_ra = '0;
    dp_we = 1'b0; dp_wa = '0; dp_wd = '0; dp_ra = '0;
    sz_we = 1'b0; sz_wa = '0; sz_wd = '0; sz_ra = '0;
    tt_we = 1'b0; tt_wa = '0; tt_wd = '0; tt_ra = '0;
    od_we = 1'b0; od_wa = '0; od_wd = '0; od_ra = '0;
    case (cmd.op)
      ST_CLR: begin
        hd_we = 1'b1; hd_wa = clr_r;
        sn_we = 1'b1; sn_wa = clr_r;
      end
      ST_LD_RA: hd_ra = nidx(a_r);
      ST_LD_WA: begin
        tg_we = 1'b1; tg_wa = s_r; tg_wd = b_r;
        lk_we = 1'b1; lk_wa = s_r; lk_wd = hd_rd;
        hd_we = 1'b1; hd_wa = nidx(a_r); hd_wd = s_r + SLOT_AW'(1);
      end
      ST_LD_RB: hd_ra = nidx(b_r);
      ST_LD_WB: begin
        tg_we = 1'b1; tg_wa = s_r; tg_wd = a_r;
        lk_we = 1'b1; lk_wa = s_r; lk_wd = hd_rd;
        hd_we = 1'b1; hd_wa = nidx(b_r); hd_wd = s_r + SLOT_AW'(1);
      end
      ST_BFS_INIT: begin
        od_we = 1'b1; od_wd = ID_W'(1);
        sn_we = 1'b1; sn_wd = 1'b1;
        dp_we = 1'b1;
        sz_we = 1'b1; sz_wd = SIZE_W'(1);
      end
      ST_BFS_POP: od_ra = qh_r[NODE_AW-1:0];
      ST_BFS_U: begin
        hd_ra = nidx(od_rd);
        dp_ra = nidx(od_rd);
      end
      ST_BFS_E: begin
        tg_ra = e_r - SLOT_AW'(1);
        lk_ra = e_r - SLOT_AW'(1);
      end
      ST_BFS_V: sn_ra = nidx(tg_rd);
      ST_BFS_S: begin
        if (!sn_rd) begin
          sn_we = 1'b1; sn_wa = nidx(v_r); sn_wd = 1'b1;
          pa_we = 1'b1; pa_wa = nidx(v_r); pa_wd = u_r;
          dp_we = 1'b1; dp_wa = nidx(v_r); dp_wd = du_r + DEP_W'(1);
          sz_we = 1'b1; sz_wa = nidx(v_r); sz_wd = SIZE_W'(1);
          od_we = 1'b1; od_wa = qt_r[NODE_AW-1:0]; od_wd = v_r;
        end
      end
      ST_REV_A: od_ra = i_r[NODE_AW-1:0];
      ST_REV_B: begin
        pa_ra = nidx(od_rd);
        sz_ra = nidx(od_rd);
      end
      ST_REV_C: sz_ra = nidx(pa_rd);
      ST_REV_D: begin
        sz_we = 1'b1; sz_wa = nidx(p_r); sz_wd = sz_rd + su_r;
      end
      ST_FWD_INIT: begin
        tt_we = 1'b1; tt_wd = tot1_r;
      end
      ST_FWD_A: od_ra = i_r[NODE_AW-1:0];
      ST_FWD_B: begin
        pa_ra = nidx(od_rd);
        sz_ra = nidx(od_rd);
      end
      ST_FWD_C: tt_ra = nidx(pa_rd);
      ST_FWD_D: begin
        tt_we = 1'b1; tt_wa = nidx(v_r); tt_wd = tnew;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= ID_W'(2);
      s_r         <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        n_r <= cfg_node_count;
      end
      if (cmd.op == ST_CLR) begin
        clr_r <= sts.clr_done ? '0 : clr_r + NODE_AW'(1);
      end
      if (cmd.op == ST_LD_WA || cmd.op == ST_LD_WB) begin
        s_r <= s_r + SLOT_AW'(1);
      end
      if (cmd.op == ST_FIN && out_free) begin
        s_r         <= '0;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      a_r    <= in_edge_from;
      b_r    <= in_edge_to;
      last_r <= in_last_edge;
    end
    if (cmd.op == ST_FIN && out_free) begin
      out_best_r <= best_r;
    end
    case (cmd.op)
      ST_BFS_INIT: begin
        qh_r   <= '0;
        qt_r   <= CNT_W'(1);
        tot1_r <= '0;
      end
      ST_BFS_POP: begin
        if (sts.q_empty) i_r <= qt_r - CNT_W'(1);
        else qh_r <= qh_r + CNT_W'(1);
      end
      ST_BFS_U:  u_r <= od_rd;
      ST_BFS_U2: begin
        e_r  <= hd_rd;
        du_r <= dp_rd;
      end
      ST_BFS_V: begin
        v_r <= tg_rd;
        e_r <= lk_rd;
      end
      ST_BFS_S: begin
        if (!sn_rd) begin
          qt_r   <= qt_r + CNT_W'(1);
          tot1_r <= tot1_r + TOT_W'(du_r) + TOT_W'(1);
        end
      end
      ST_REV_C: begin
        p_r  <= pa_rd;
        su_r <= sz_rd;
      end
      ST_REV_D: i_r <= i_r - CNT_W'(1);
      ST_FWD_INIT: begin
        i_r       <= CNT_W'(1);
        best_r    <= ID_W'(1);
        bestval_r <= tot1_r;
      end
      ST_FWD_B: v_r  <= od_rd;
      ST_FWD_C: su_r <= sz_rd;
      ST_FWD_D: begin
        if (tnew > bestval_r || (tnew == bestval_r && v_r < best_r)) begin
          best_r    <= v_r;
          bestval_r <= tnew;
        end
        i_r <= i_r + CNT_W'(1);
      end
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_best_root = out_best_r;

  trmds_ram #(.WIDTH(SLOT_AW), .DEPTH(MAX_NODES)) u_head (
    .clk(clk), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
  trmds_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_seen (
    .clk(clk), .we(sn_we), .waddr(sn_wa), .wdata(sn_wd), .raddr(sn_ra), .rdata(sn_rd));
  trmds_ram #(.WIDTH(ID_W), .DEPTH(2 * MAX_NODES)) u_target (
    .clk(clk), .we(tg_we), .waddr(tg_wa), .wdata(tg_wd), .raddr(tg_ra), .rdata(tg_rd));
  trmds_ram #(.WIDTH(SLOT_AW), .DEPTH(2 * MAX_NODES)) u_link (
    .clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd));
  trmds_ram #(.WIDTH(ID_W), .DEPTH(MAX_NODES)) u_parent (
    .clk(clk), .we(pa_we), .waddr(pa_wa), .wdata(pa_wd), .raddr(pa_ra), .rdata(pa_rd));
  trmds_ram #(.WIDTH(DEP_W), .DEPTH(MAX_NODES)) u_depth (
    .clk(clk), .we(dp_we), .waddr(dp_wa), .wdata(dp_wd), .raddr(dp_ra), .rdata(dp_rd));
  trmds_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_NODES)) u_size (
    .clk(clk), .we(sz_we), .waddr(sz_wa), .wdata(sz_wd), .raddr(sz_ra), .rdata(sz_rd));
  trmds_ram #(.WIDTH(TOT_W), .DEPTH(MAX_NODES)) u_total (
    .clk(clk), .we(tt_we), .waddr(tt_wa), .wdata(tt_wd), .raddr(tt_ra), .rdata(tt_rd));
  trmds_ram #(.WIDTH(ID_W), .DEPTH(MAX_NODES)) u_order (
    .clk(clk), .we(od_we), .waddr(od_wa), .wdata(od_wd), .raddr(od_ra), .rdata(od_rd));

endmodule

// ===== rtl/tree_reroot_max_depth_sum.sv =====
// tree_reroot_max_depth_sum: top level, sequencer plus datapath.
// Depends on trmds_pkg, trmds_ctrl, trmds_dpath (and trmds_ram below it).
//
//  channel | ports                                         | request moves
//  in      | in_valid, in_stall, in_edge_from/to/last_edge | one tree edge
//  out     | out_valid, out_stall, out_best_root           | best root node
//  cfg     | cfg_we, cfg_node_count                        | node count write
//
// An edge is dropped after its check, or stored with two head-list updates
// through one adjacency RAM port. The last edge adds the walk, then the
// subtree-sum pass and the rerooting pass. Reset and each result start a
// sweep over all MAX_NODES list heads and visited bits, clearing them; no
// request is taken during it. A stalled result holds and the next edges
// still load.
module tree_reroot_max_depth_sum #(
  parameter int MAX_NODES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [trmds_pkg::ID_W-1:0] in_edge_from,
  input  logic [trmds_pkg::ID_W-1:0] in_edge_to,
  input  logic                       in_last_edge,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [trmds_pkg::ID_W-1:0] out_best_root,
  input  logic                       cfg_we,
  input  logic [trmds_pkg::ID_W-1:0] cfg_node_count
);
  import trmds_pkg::*;

  cmd_t cmd;
  sts_t sts;

  trmds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  trmds_dpath #(.MAX_NODES(MAX_NODES)) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_edge_from   (in_edge_from),
    .in_edge_to     (in_edge_to),
    .in_last_edge   (in_last_edge),
    .cfg_we         (cfg_we),
    .cfg_node_count (cfg_node_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_best_root  (out_best_root)
  );

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.op == ST_FIN))
    else $error("result raised outside final step");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while previous one in flight");

  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == ST_FIN && !sts.out_free) |=> (cmd.op == ST_FIN))
    else $error("result dropped while output stalled");

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for tree_reroot_max_depth_sum. Loads random and
// directed trees edge by edge and checks the best root. Depends on the RTL only.
`timescale 1ns / 1ps

class root_scoreboard;
  int unsigned errors;
  bit [10:0]   expected_roots[$];
  int unsigned node_cnt;
  int unsigned head[1025];
  int unsigned tgt[2048];
  int unsigned lnk[2048];
  int unsigned stored;

  function void clear_lists();
    foreach (head[i]) head[i] = 0;
    stored = 0;
  endfunction

  function void set_nodes(bit [10:0] v);
    node_cnt = v;
  endfunction

  function int unsigned eff_n();
    if (node_cnt < 1) return 1;
    if (node_cnt > 1024) return 1024;
    return node_cnt;
  endfunction

  function void add_arc(int unsigned a, int unsigned b);
    tgt[stored] = b;
    lnk[stored] = head[a];
    head[a] = stored + 1;
    stored++;
  endfunction

  function bit [10:0] best_root_of_tree();
    int unsigned n, qh, qt, u, e, v, best;
    int unsigned order[1024];
    int unsigned par[1025];
    int unsigned dep[1025];
    longint unsigned sz[1025];
    longint unsigned tot[1025];
    bit seen[1025];
    n = eff_n();
    foreach (seen[i]) seen[i] = 0;
    qh = 0; qt = 0;
    order[qt] = 1; qt++;
    seen[1] = 1; par[1] = 0; dep[1] = 0;
    while (qh < qt) begin
      u = order[qh];
      qh++;
      e = head[u];
      while (e != 0) begin
        v = tgt[e-1];
        if (v >= 1 && v <= n && !seen[v] && qt < 1024) begin
          seen[v] = 1; par[v] = u; dep[v] = dep[u] + 1;
          order[qt] = v;
          qt++;
        end
        e = lnk[e-1];
      end
    end
    tot[1] = 0;
    for (int i = 0; i < qt; i++) begin
      sz[order[i]] = 1;
      tot[1] += dep[order[i]];
    end
    for (int i = qt; i > 1; i--) sz[par[order[i-1]]] += sz[order[i-1]];
    for (int i = 1; i < qt; i++) begin
      v = order[i];
      tot[v] = tot[par[v]] + n - 2 * sz[v];
    end
    best = 1;
    for (int i = 2; i <= n; i++)
      if (seen[i] && tot[i] > tot[best]) best = i;
    return 11'(best);
  endfunction

  function void note_edge(bit [10:0] a, bit [10:0] b, bit last);
    int unsigned n;
    n = eff_n();
    if (a >= 1 && a <= n && b >= 1 && b <= n && stored + 2 <= 2046) begin
      add_arc(a, b);
      add_arc(b, a);
    end
    if (last) begin
      expected_roots = {expected_roots, best_root_of_tree()};
      clear_lists();
    end
  endfunction

  task report(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  task check_root(bit [10:0] got);
    bit [10:0] want;
    if (expected_roots.size() == 0) begin
      report($sformatf("unexpected best_root %0d", got));
      return;
    end
    want = expected_roots.pop_front();
    if (got !== want) begin
      report($sformatf("best_root got %0d want %0d", got, want));
    end
  endtask
endclass

module tb;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [10:0] in_edge_from;
  logic [10:0] in_edge_to;
  logic        in_last_edge;
  logic        out_valid;
  logic        out_stall;
  logic [10:0] out_best_root;
  logic        cfg_we;
  logic [10:0] cfg_node_count;

  root_scoreboard sb;
  bit          calm;
  bit          hold_off;
  int unsigned quiet_cycles;
  int unsigned items_sent;

  localparam int unsigned WATCHDOG_LIMIT = 200000;

  tree_reroot_max_depth_sum #(.MAX_NODES(1024)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_edge_from(in_edge_from), .in_edge_to(in_edge_to), .in_last_edge(in_last_edge),
    .out_valid(out_valid), .out_stall(out_stall), .out_best_root(out_best_root),
    .cfg_we(cfg_we), .cfg_node_count(cfg_node_count)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // result side: random stall bursts plus one long hold-off
  initial begin
    int unsigned burst;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 6);
        out_stall <= 1'b1;
        repeat (burst - 1) @(posedge clk);
        @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_root(out_best_root);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_edge(input bit [10:0] a, input bit [10:0] b, input bit last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_edge_from <= a;
    in_edge_to   <= b;
    in_last_edge <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_edge(a, b, last);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_roots.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic set_node_count(input bit [10:0] v);
    drain();
    cfg_we         <= 1'b1;
    cfg_node_count <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_nodes(v);
  endtask

  // random tree on n nodes: each node attaches to an earlier one, labels permuted
  task automatic send_tree(input int unsigned n, input int unsigned shape);
    int unsigned lbl[$];
    int unsigned p, j, t;
    for (int i = 1; i <= n; i++) lbl = {lbl, i};
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = lbl[i]; lbl[i] = lbl[j]; lbl[j] = t;
    end
    for (int i = 1; i < n; i++) begin
      case (shape)
        0: p = i - 1;
        1: p = 0;
        default: p = $urandom_range(0, i - 1);
      endcase
      if ($urandom_range(0, 1)) send_edge(11'(lbl[i]), 11'(lbl[p]), i == n - 1);
      else send_edge(11'(lbl[p]), 11'(lbl[i]), i == n - 1);
    end
  endtask

  initial begin
    int unsigned n;
    sb = new();
    sb.clear_lists();
    sb.set_nodes(2);
    calm = 0; hold_off = 0; items_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0; in_edge_from = '0; in_edge_to = '0; in_last_edge = 1'b0;
    cfg_we = 1'b0; cfg_node_count = 11'd2;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default size, out-of-range ends, zero node count, forest
    send_edge(1, 2, 1);
    send_edge(2, 1, 1);
    send_edge(0, 2, 1);
    send_edge(11'h7FF, 11'h400, 1);
    send_edge(1, 1, 1);
    set_node_count(0);
    send_edge(1, 1, 1);
    set_node_count(11'h7FF);
    send_edge(11'h7FF, 1, 0);
    send_edge(1024, 1, 1);
    set_node_count(5);
    send_edge(2, 3, 0);
    send_edge(4, 5, 0);
    send_edge(3, 6, 1);
    send_edge(1, 2, 0);
    send_edge(2, 3, 0);
    send_edge(1, 3, 0);
    send_edge(3, 4, 0);
    send_edge(4, 5, 1);
    set_node_count(1024);
    // full-length path fills all 2046 usable slots; the trailing edges no longer fit
    for (int i = 1; i < 1024; i++) send_edge(11'(i), 11'(i + 1), 0);
    send_edge(3, 700, 0);
    send_edge(1, 1024, 1);

    // long output hold-off while edges keep coming
    set_node_count(6);
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      for (int k = 0; k < 8; k++) send_tree(6, 2);
    join

    while (items_sent < 1500) begin
      if ($urandom_range(0, 9) == 0) n = $urandom_range(2, 200);
      else n = $urandom_range(2, 16);
      set_node_count(11'(n));
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(0, 7) == 0)
          for (int i = 0; i < n; i++)
            send_edge(11'($urandom_range(0, 2047)), 11'($urandom_range(0, n + 1)),
                      i == n - 1);
        else
          send_tree(n, $urandom_range(0, 4));
      end
      if (items_sent > 1350) calm = 1;
    end

    drain();
    if (sb.errors == 0 && sb.expected_roots.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
